// ----- hw/rtl/gyro_quaternion_integrator_unit_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef GYRO_QUATERNION_INTEGRATOR_UNIT_MACROS_SVH
`define GYRO_QUATERNION_INTEGRATOR_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define GQI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gqi assertion failed");

// Implication form, same clocking.
`define GQI_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gqi assertion failed");

`endif

// ----- hw/rtl/gqi_pkg.sv -----
`timescale 1ns / 1ps

package gqi_pkg;

    localparam int QUAT_WIDTH = 32;
    localparam int RATE_WIDTH = 16;
    // shared multiplier operand width (signed)
    localparam int MUL_W = 33;

    localparam logic [31:0] HALF_ANGLE_K = 32'd2515284534;
    localparam longint WORK_MAX = 64'sd2147483647;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [3:0] N_STEPS = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AMUL,
        S_AACC,
        S_QMUL,
        S_QACC,
        S_CLAMP,
        S_SMUL,
        S_SACC,
        S_ROOTLD,
        S_SQRT,
        S_DIVLD,
        S_DIV,
        S_DIVST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] src;
        logic [1:0] ang;
        logic [1:0] dst;
        logic       sub;
    } t_step;

    // Derivative products: w[src] * angle[ang] added to / subtracted from n[dst].
    function automatic t_step prod_step(input logic [3:0] idx);
        t_step s;
        case (idx)
            4'd0:    s = '{2'd1, 2'd0, 2'd0, 1'b1};
            4'd1:    s = '{2'd2, 2'd1, 2'd0, 1'b1};
            4'd2:    s = '{2'd3, 2'd2, 2'd0, 1'b1};
            4'd3:    s = '{2'd0, 2'd0, 2'd1, 1'b0};
            4'd4:    s = '{2'd2, 2'd2, 2'd1, 1'b0};
            4'd5:    s = '{2'd3, 2'd1, 2'd1, 1'b1};
            4'd6:    s = '{2'd0, 2'd1, 2'd2, 1'b0};
            4'd7:    s = '{2'd1, 2'd2, 2'd2, 1'b1};
            4'd8:    s = '{2'd3, 2'd0, 2'd2, 1'b0};
            4'd9:    s = '{2'd0, 2'd2, 2'd3, 1'b0};
            4'd10:   s = '{2'd1, 2'd1, 2'd3, 1'b0};
            4'd11:   s = '{2'd2, 2'd0, 2'd3, 1'b1};
            default: s = '{2'd0, 2'd0, 2'd0, 1'b0};
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/gyro_quaternion_integrator_unit.sv -----
// Each item runs through the angle, derivative, norm, square root and divide steps in turn;
// a zero norm skips the root and divide. o_ready is high only when idle, so a new item
// is taken only after the previous result is emitted. The bit-serial divider and the
// 32-step square root follow the products, which all share one 33x33 multiplier.
// Reset (sync, active low) returns the attitude to identity and drops o_valid.
`timescale 1ns / 1ps

module gyro_quaternion_integrator_unit #(
    parameter int QUAT_WIDTH = gqi_pkg::QUAT_WIDTH,
    parameter int RATE_WIDTH = gqi_pkg::RATE_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [RATE_WIDTH-1:0] i_rate_x,
    input  logic signed [RATE_WIDTH-1:0] i_rate_y,
    input  logic signed [RATE_WIDTH-1:0] i_rate_z,
    input  logic        [15:0]           i_elapsed_us,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [QUAT_WIDTH-1:0] o_quat_w_out,
    output logic signed [QUAT_WIDTH-1:0] o_quat_x_out,
    output logic signed [QUAT_WIDTH-1:0] o_quat_y_out,
    output logic signed [QUAT_WIDTH-1:0] o_quat_z_out
);

    localparam int D   = QUAT_WIDTH - 32;
    localparam int MW  = gqi_pkg::MUL_W;
    localparam int PW  = 2 * MW;
    localparam int M_W = RATE_WIDTH + 16;
    localparam logic signed [34:0] NMAX = 35'(gqi_pkg::WORK_MAX);
    localparam logic signed [PW-1:0] RND29 = PW'(64'sd536870912);

    gqi_pkg::t_state r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] r_sub, n_sub;
    logic [5:0] r_it, n_it;
    logic       r_ovalid;

    logic [RATE_WIDTH-1:0]    r_mag [3];
    logic [2:0]               r_neg;
    logic [15:0]              r_e;
    logic [M_W-1:0]           r_m;
    logic [63:0]              r_h;
    logic signed [31:0]       r_ang [3];
    logic signed [31:0]       r_w [4];
    logic signed [34:0]       r_n [4];
    logic signed [31:0]       r_c [4];
    logic signed [31:0]       r_o [4];
    logic signed [PW-1:0]     r_prod;
    logic [63:0]              r_s;
    logic [63:0]              r_x;
    logic [33:0]              r_rem;
    logic [31:0]              r_root;
    logic [61:0]              r_dvd;
    logic [61:0]              r_q;
    logic [31:0]              r_drem;
    logic signed [QUAT_WIDTH-1:0] r_att [4];
    logic signed [QUAT_WIDTH-1:0] r_out [4];

    logic signed [31:0]       wq [4];
    logic signed [QUAT_WIDTH-1:0] att_new [4];
    logic signed [MW-1:0]     mul_a, mul_b;
    gqi_pkg::t_step           step;
    logic                     accept;
    logic                     emit;

    assign accept = i_valid && o_ready;
    assign emit   = (r_state == gqi_pkg::S_DONE) && (!r_ovalid || i_ready);
    assign step   = gqi_pkg::prod_step(r_cnt);

    // state format <-> Q30 working format
    for (genvar g = 0; g < 4; g++) begin : g_fmt
        if (D > 0) begin : g_wide
            logic signed [QUAT_WIDTH:0] tq;
            logic signed [QUAT_WIDTH:0] to;
            always_comb begin
                tq = ((QUAT_WIDTH+1)'(r_att[g]) + (QUAT_WIDTH+1)'(1 <<< (D - 1))) >>> D;
                if (tq > (QUAT_WIDTH+1)'(gqi_pkg::WORK_MAX)) begin
                    wq[g] = 32'(gqi_pkg::WORK_MAX);
                end else if (tq < -(QUAT_WIDTH+1)'(gqi_pkg::WORK_MAX)) begin
                    wq[g] = -32'(gqi_pkg::WORK_MAX);
                end else begin
                    wq[g] = tq[31:0];
                end
                to = (QUAT_WIDTH+1)'(r_o[g]) <<< D;
                att_new[g] = to[QUAT_WIDTH-1:0];
            end
        end else begin : g_narrow
            logic signed [32:0] tq;
            logic signed [32:0] to;
            logic signed [32:0] lim_hi;
            logic signed [32:0] lim_lo;
            always_comb begin
                lim_hi = 33'(64'sd1 <<< (QUAT_WIDTH - 1)) - 33'sd1;
                lim_lo = -33'(64'sd1 <<< (QUAT_WIDTH - 1));
                tq = 33'(r_att[g]) <<< (-D);
                if (tq > 33'(gqi_pkg::WORK_MAX)) begin
                    wq[g] = 32'(gqi_pkg::WORK_MAX);
                end else if (tq < -33'(gqi_pkg::WORK_MAX)) begin
                    wq[g] = -32'(gqi_pkg::WORK_MAX);
                end else begin
                    wq[g] = tq[31:0];
                end
                if (D == 0) begin
                    to = 33'(r_o[g]);
                end else begin
                    to = (33'(r_o[g]) + 33'(64'sd1 <<< (-D - 1))) >>> (-D);
                end
                if (to > lim_hi) begin
                    att_new[g] = lim_hi[QUAT_WIDTH-1:0];
                end else if (to < lim_lo) begin
                    att_new[g] = lim_lo[QUAT_WIDTH-1:0];
                end else begin
                    att_new[g] = to[QUAT_WIDTH-1:0];
                end
            end
        end
    end

    // next state and sequencer counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sub   = r_sub;
        n_it    = r_it;
        case (r_state)
            gqi_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = gqi_pkg::S_AMUL;
                    n_cnt   = '0;
                    n_sub   = '0;
                end
            end
            gqi_pkg::S_AMUL: n_state = gqi_pkg::S_AACC;
            gqi_pkg::S_AACC: begin
                if (r_sub == 2'd2) begin
                    n_sub = '0;
                    if (r_cnt == 4'd2) begin
                        n_cnt   = '0;
                        n_state = gqi_pkg::S_QMUL;
                    end else begin
                        n_cnt   = r_cnt + 4'd1;
                        n_state = gqi_pkg::S_AMUL;
                    end
                end else begin
                    n_sub   = r_sub + 2'd1;
                    n_state = gqi_pkg::S_AMUL;
                end
            end
            gqi_pkg::S_QMUL: n_state = gqi_pkg::S_QACC;
            gqi_pkg::S_QACC: begin
                if (r_cnt == gqi_pkg::N_STEPS - 4'd1) begin
                    n_cnt   = '0;
                    n_state = gqi_pkg::S_CLAMP;
                end else begin
                    n_cnt   = r_cnt + 4'd1;
                    n_state = gqi_pkg::S_QMUL;
                end
            end
            gqi_pkg::S_CLAMP: n_state = gqi_pkg::S_SMUL;
            gqi_pkg::S_SMUL:  n_state = gqi_pkg::S_SACC;
            gqi_pkg::S_SACC: begin
                if (r_cnt == 4'd3) begin
                    n_cnt   = '0;
                    n_state = gqi_pkg::S_ROOTLD;
                end else begin
                    n_cnt   = r_cnt + 4'd1;
                    n_state = gqi_pkg::S_SMUL;
                end
            end
            gqi_pkg::S_ROOTLD: begin
                n_it    = '0;
                n_state = (r_s == 64'd0) ? gqi_pkg::S_DONE : gqi_pkg::S_SQRT;
            end
            gqi_pkg::S_SQRT: begin
                n_it = r_it + 6'd1;
                if (r_it == 6'd31) begin
                    n_cnt   = '0;
                    n_state = gqi_pkg::S_DIVLD;
                end
            end
            gqi_pkg::S_DIVLD: begin
                n_it    = '0;
                n_state = gqi_pkg::S_DIV;
            end
            gqi_pkg::S_DIV: begin
                n_it = r_it + 6'd1;
                if (r_it == 6'd61) begin
                    n_state = gqi_pkg::S_DIVST;
                end
            end
            gqi_pkg::S_DIVST: begin
                n_cnt   = r_cnt + 4'd1;
                n_state = (r_cnt == 4'd3) ? gqi_pkg::S_DONE : gqi_pkg::S_DIVLD;
            end
            gqi_pkg::S_DONE: begin
                if (emit) begin
                    n_state = gqi_pkg::S_IDLE;
                end
            end
            default: n_state = gqi_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and shared multiplier operands
    always_comb begin
        o_ready = (r_state == gqi_pkg::S_IDLE);
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            gqi_pkg::S_AMUL: begin
                case (r_sub)
                    2'd0: begin
                        mul_a = MW'(r_mag[r_cnt[1:0]]);
                        mul_b = MW'(r_e);
                    end
                    2'd1: begin
                        mul_a = MW'(r_m[M_W-1:16]);
                        mul_b = MW'(gqi_pkg::HALF_ANGLE_K);
                    end
                    default: begin
                        mul_a = MW'(r_m[15:0]);
                        mul_b = MW'(gqi_pkg::HALF_ANGLE_K);
                    end
                endcase
            end
            gqi_pkg::S_QMUL: begin
                mul_a = MW'(r_w[step.src]);
                mul_b = MW'(r_ang[step.ang]);
            end
            gqi_pkg::S_SMUL: begin
                mul_a = MW'(r_c[r_cnt[1:0]]);
                mul_b = MW'(r_c[r_cnt[1:0]]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // control registers and attitude state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gqi_pkg::S_IDLE;
            r_cnt    <= '0;
            r_sub    <= '0;
            r_it     <= '0;
            r_ovalid <= 1'b0;
            r_att[0] <= QUAT_WIDTH'(64'sd1 <<< (QUAT_WIDTH - 2));
            r_att[1] <= '0;
            r_att[2] <= '0;
            r_att[3] <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sub   <= n_sub;
            r_it    <= n_it;
            if (emit) begin
                r_ovalid <= 1'b1;
                for (int i = 0; i < 4; i++) begin
                    r_att[i] <= att_new[i];
                end
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    logic [81:0]          ang_tot;
    logic [31:0]          ang_mag;
    logic signed [PW-1:0] prnd;
    logic signed [34:0]   pq;
    logic [35:0]          sq_t;
    logic [35:0]          sq_trial;
    logic [32:0]          dv_t;
    logic [31:0]          c_abs;
    logic [30:0]          q_mag;

    always_comb begin
        ang_tot = {2'b00, r_h, 16'h0000} + {34'd0, r_prod[47:0]} + 82'h8000_0000;
        ang_mag = (ang_tot[81:32] > 50'(gqi_pkg::WORK_MAX)) ?
                  32'(gqi_pkg::WORK_MAX) : ang_tot[63:32];
        prnd    = (r_prod + RND29) >>> 30;
        pq      = prnd[34:0];
        sq_t    = {r_rem, r_x[63:62]};
        sq_trial = {2'b00, r_root, 2'b01};
        dv_t    = {r_drem, r_dvd[61]};
        c_abs   = r_c[r_cnt[1:0]][31] ? 32'(-r_c[r_cnt[1:0]]) : 32'(r_c[r_cnt[1:0]]);
        q_mag   = (r_q > 62'(gqi_pkg::WORK_MAX)) ? 31'(gqi_pkg::WORK_MAX) : r_q[30:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            gqi_pkg::S_IDLE: begin
                if (accept) begin
                    r_neg    <= {i_rate_z[RATE_WIDTH-1], i_rate_y[RATE_WIDTH-1],
                                 i_rate_x[RATE_WIDTH-1]};
                    r_mag[0] <= i_rate_x[RATE_WIDTH-1] ? -i_rate_x : i_rate_x;
                    r_mag[1] <= i_rate_y[RATE_WIDTH-1] ? -i_rate_y : i_rate_y;
                    r_mag[2] <= i_rate_z[RATE_WIDTH-1] ? -i_rate_z : i_rate_z;
                    r_e      <= i_elapsed_us;
                    for (int i = 0; i < 4; i++) begin
                        r_w[i] <= wq[i];
                        r_n[i] <= 35'(wq[i]);
                    end
                end
            end
            gqi_pkg::S_AACC: begin
                case (r_sub)
                    2'd0:    r_m <= r_prod[M_W-1:0];
                    2'd1:    r_h <= r_prod[63:0];
                    default: r_ang[r_cnt[1:0]] <= r_neg[r_cnt[1:0]] ?
                                                  -$signed(ang_mag) : $signed(ang_mag);
                endcase
            end
            gqi_pkg::S_QACC: begin
                r_n[step.dst] <= step.sub ? r_n[step.dst] - pq : r_n[step.dst] + pq;
            end
            gqi_pkg::S_CLAMP: begin
                for (int i = 0; i < 4; i++) begin
                    if (r_n[i] > NMAX) begin
                        r_c[i] <= NMAX[31:0];
                    end else if (r_n[i] < -NMAX) begin
                        r_c[i] <= 32'(-NMAX);
                    end else begin
                        r_c[i] <= r_n[i][31:0];
                    end
                end
                r_s <= '0;
            end
            gqi_pkg::S_SACC: r_s <= r_s + r_prod[63:0];
            gqi_pkg::S_ROOTLD: begin
                r_x    <= r_s;
                r_rem  <= '0;
                r_root <= '0;
                if (r_s == 64'd0) begin
                    r_o[0] <= gqi_pkg::ONE_Q30;
                    r_o[1] <= '0;
                    r_o[2] <= '0;
                    r_o[3] <= '0;
                end
            end
            gqi_pkg::S_SQRT: begin
                // two radicand bits per step
                r_x <= {r_x[61:0], 2'b00};
                if (sq_t >= sq_trial) begin
                    r_rem  <= 34'(sq_t - sq_trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= sq_t[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            gqi_pkg::S_DIVLD: begin
                // round to nearest: add half the divisor
                r_dvd  <= {c_abs[30:0], 30'd0} + {31'd0, r_root[31:1]};
                r_drem <= '0;
                r_q    <= '0;
            end
            gqi_pkg::S_DIV: begin
                r_dvd <= {r_dvd[60:0], 1'b0};
                if (dv_t >= {1'b0, r_root}) begin
                    r_drem <= 32'(dv_t - {1'b0, r_root});
                    r_q    <= {r_q[60:0], 1'b1};
                end else begin
                    r_drem <= dv_t[31:0];
                    r_q    <= {r_q[60:0], 1'b0};
                end
            end
            gqi_pkg::S_DIVST: begin
                r_o[r_cnt[1:0]] <= r_c[r_cnt[1:0]][31] ? -$signed({1'b0, q_mag})
                                                       : $signed({1'b0, q_mag});
            end
            gqi_pkg::S_DONE: begin
                if (emit) begin
                    for (int i = 0; i < 4; i++) begin
                        r_out[i] <= att_new[i];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_quat_w_out = r_out[0];
    assign o_quat_x_out = r_out[1];
    assign o_quat_y_out = r_out[2];
    assign o_quat_z_out = r_out[3];

endmodule

// ----- hw/rtl/gqi_checker.sv -----
`timescale 1ns / 1ps
`include "gyro_quaternion_integrator_unit_macros.svh"

module gqi_checker #(
    parameter int QUAT_WIDTH = gqi_pkg::QUAT_WIDTH
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [QUAT_WIDTH-1:0] o_quat_w_out
);

    // a waiting result holds (checked on the w component)
    `GQI_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_quat_w_out))
    // the block is busy right after taking an item
    `GQI_ASSERT_IMP(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // a result only appears at the end of a computation
    `GQI_ASSERT(a_result_from_busy, i_clk, i_rst_n, $rose(o_valid) |-> !$past(o_ready))

endmodule

bind gyro_quaternion_integrator_unit gqi_checker #(
    .QUAT_WIDTH(QUAT_WIDTH)
) u_gqi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_quat_w_out (o_quat_w_out)
);
